### rtl/pts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types, constants and register map of the periodic test-pattern
// source.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int CHANNELS  = 4;
    localparam int MAX_WORDS = 16;

    localparam int CH_AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int WIDX_W  = $clog2(MAX_WORDS);
    localparam int WCNT_W  = $clog2(MAX_WORDS + 1);

    localparam int NUM_REGS = 7;
    localparam int PADDR_W  = $clog2(NUM_REGS * 4);
    localparam int REGIDX_W = PADDR_W - 2;

    localparam int LATE_W = 32;
    localparam int PER_W  = 16;

    localparam logic [31:0] EP_CH0       = 32'h0000_0013;
    localparam logic [31:0] EP_CH1       = 32'h0000_0001;
    localparam logic [31:0] TOGGLE_EVEN  = 32'hAAAA_AAAA;
    localparam logic [31:0] TOGGLE_ODD   = 32'h5555_5555;
    localparam logic [31:0] CNT_MARK     = 32'hC000_0000;
    localparam logic [41:0] US_PER_MS    = 42'd1000;

    localparam logic [PER_W-1:0] PERIOD_RST = 16'd100;
    localparam logic [19:0]      WORDS_RST  = 20'd135300;

    typedef enum logic [REGIDX_W-1:0] {
        REG_ENABLE  = 3'd0,
        REG_PERIOD0 = 3'd1,
        REG_PERIOD1 = 3'd2,
        REG_PERIOD2 = 3'd3,
        REG_PERIOD3 = 3'd4,
        REG_PATTERN = 3'd5,
        REG_WORDS   = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_POLL     = 2'd0,
        MODE_RESTART  = 2'd1,
        MODE_RST_LOST = 2'd2,
        MODE_RSVD     = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        PAT_COUNTER = 2'd0,
        PAT_RAMP    = 2'd1,
        PAT_TOGGLE  = 2'd2,
        PAT_COUNT2  = 2'd3
    } t_pattern;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_WRITE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [31:0] sample;
        logic [31:0] emitted;
        logic [31:0] lost;
        logic [31:0] due;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

### rtl/periodic_test_pattern_source_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_test_pattern_source_unit
// Four-channel periodic test-pattern source. Per-channel counters and due
// time live in one small RAM; a poll that fires reads the entry, divides
// lateness by the period, writes it back and streams the sample words.
//
//   Channel  Direction  Handshake                  Payload
//   in       sink       i_in_valid / o_in_ready    i_mode, i_channel, i_now_ms
//   out      source     o_out_valid / i_out_ready  o_fired .. o_lost_total
//   cfg      APB slave  psel/penable/pwrite/pready paddr, pwdata, prdata
//
// A poll that fires passes from accept through entry read, the radix-4
// divider (16 steps and the done pulse), write-back and the sample words,
// one word per cycle while the output is not stalled, and returns to idle
// to take the next item. Restarts and lost-count resets pass through
// write-back; other items go from entry read to output. One item at a time.
// Output stalls hold the word stream; a new item is accepted while the
// final beat of the previous one still waits in the output register.
// Reset is synchronous; channel entries read as zero until first written.
// ----------------------------------------------------------------------------
module periodic_test_pattern_source_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pts_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,

    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_mode,
    input  logic [1:0]                  i_channel,
    input  logic [31:0]                 i_now_ms,

    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_fired,
    output logic [1:0]                  o_event_channel,
    output logic [41:0]                 o_time_us,
    output logic                        o_overflow,
    output logic [31:0]                 o_missed_periods,
    output logic [31:0]                 o_sample_number,
    output logic [3:0]                  o_word_index,
    output logic [31:0]                 o_data_word,
    output logic                        o_last,
    output logic [31:0]                 o_emitted_total,
    output logic [31:0]                 o_lost_total
);

    // ---------------- configuration registers ----------------
    logic [3:0]                 r_enable;
    logic [pts_pkg::PER_W-1:0]  r_period [4];
    logic [7:0]                 r_pattern;
    logic [19:0]                r_word_counts;

    pts_pkg::t_reg_idx          cfg_idx;
    logic                       cfg_wr;

    assign cfg_idx = pts_pkg::t_reg_idx'(paddr[pts_pkg::PADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable      <= '0;
            r_period[0]   <= pts_pkg::PERIOD_RST;
            r_period[1]   <= pts_pkg::PERIOD_RST;
            r_period[2]   <= pts_pkg::PERIOD_RST;
            r_period[3]   <= pts_pkg::PERIOD_RST;
            r_pattern     <= '0;
            r_word_counts <= pts_pkg::WORDS_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                pts_pkg::REG_ENABLE:  r_enable      <= pwdata[3:0];
                pts_pkg::REG_PERIOD0: r_period[0]   <= pwdata[15:0];
                pts_pkg::REG_PERIOD1: r_period[1]   <= pwdata[15:0];
                pts_pkg::REG_PERIOD2: r_period[2]   <= pwdata[15:0];
                pts_pkg::REG_PERIOD3: r_period[3]   <= pwdata[15:0];
                pts_pkg::REG_PATTERN: r_pattern     <= pwdata[7:0];
                pts_pkg::REG_WORDS:   r_word_counts <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            pts_pkg::REG_ENABLE:  prdata = {28'd0, r_enable};
            pts_pkg::REG_PERIOD0: prdata = {16'd0, r_period[0]};
            pts_pkg::REG_PERIOD1: prdata = {16'd0, r_period[1]};
            pts_pkg::REG_PERIOD2: prdata = {16'd0, r_period[2]};
            pts_pkg::REG_PERIOD3: prdata = {16'd0, r_period[3]};
            pts_pkg::REG_PATTERN: prdata = {24'd0, r_pattern};
            pts_pkg::REG_WORDS:   prdata = {12'd0, r_word_counts};
            default:              prdata = '0;
        endcase
    end

    // ---------------- item registers ----------------
    pts_pkg::t_state            r_state, n_state;
    pts_pkg::t_mode             r_mode;
    logic [1:0]                 r_ch;
    logic [31:0]                r_now;
    logic [41:0]                r_time_us;
    logic                       r_fire;
    logic                       r_en;
    logic [pts_pkg::PER_W-1:0]  r_per;
    logic [pts_pkg::WCNT_W-1:0] r_words;
    pts_pkg::t_pattern          r_pat;
    pts_pkg::t_entry            r_entry;
    logic [31:0]                r_base;
    logic [31:0]                r_lost_q;
    logic [pts_pkg::WIDX_W-1:0] r_widx;
    logic [pts_pkg::CHANNELS-1:0] r_ent_valid;

    logic [pts_pkg::CH_AW-1:0]  ch_addr;
    logic                       in_accept;
    logic                       out_free;
    logic                       ram_we;
    logic                       div_start;
    logic                       beat_load;
    logic                       beat_last;

    assign ch_addr   = r_ch[pts_pkg::CH_AW-1:0];
    assign in_accept = i_in_valid && o_in_ready;
    assign out_free  = !o_out_valid || i_out_ready;

    // ---------------- entry memory ----------------
    logic [pts_pkg::ENTRY_W-1:0] ram_rdata;
    pts_pkg::t_entry             w_entry;

    pts_ram #(
        .WIDTH (pts_pkg::ENTRY_W),
        .DEPTH (pts_pkg::CHANNELS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ch_addr),
        .i_wdata (w_entry),
        .i_raddr (i_channel[pts_pkg::CH_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // ---------------- evaluation ----------------
    logic                       ch_ok;
    pts_pkg::t_entry            rd_entry;
    logic [31:0]                lateness;
    logic                       en_c;
    logic                       fire_c;
    logic [pts_pkg::PER_W-1:0]  per_c;
    logic [4:0]                 wfield;
    logic [pts_pkg::WCNT_W-1:0] words_c;

    always_comb begin
        ch_ok    = int'(r_ch) < pts_pkg::CHANNELS;
        rd_entry = (ch_ok && r_ent_valid[ch_addr]) ? pts_pkg::t_entry'(ram_rdata) : '0;
        lateness = r_now - rd_entry.due;
        en_c     = ch_ok && r_enable[r_ch];
        fire_c   = (r_mode == pts_pkg::MODE_POLL) && en_c && !lateness[31];
        per_c    = (r_period[r_ch] == '0) ? pts_pkg::PER_W'(1) : r_period[r_ch];
        wfield   = r_word_counts[5 * r_ch +: 5];
        if (wfield == 5'd0) begin
            words_c = pts_pkg::WCNT_W'(1);
        end else if (int'(wfield) > pts_pkg::MAX_WORDS) begin
            words_c = pts_pkg::WCNT_W'(pts_pkg::MAX_WORDS);
        end else begin
            words_c = pts_pkg::WCNT_W'(wfield);
        end
    end

    // ---------------- divider ----------------
    logic        div_busy;
    logic        div_done;
    logic [31:0] div_q;

    pts_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (lateness),
        .i_divisor  (per_c),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // ---------------- write-back value ----------------
    logic [31:0] now_plus;

    always_comb begin
        now_plus = r_now + 32'(r_per);
        w_entry  = r_entry;
        if (r_fire) begin
            w_entry.sample  = r_entry.sample + 32'd1;
            w_entry.emitted = r_entry.emitted + 32'd1;
            w_entry.lost    = r_entry.lost + div_q;
            w_entry.due     = now_plus;
        end else if (r_mode == pts_pkg::MODE_RESTART) begin
            w_entry     = '0;
            w_entry.due = r_en ? now_plus : 32'd0;
        end else if (r_mode == pts_pkg::MODE_RST_LOST) begin
            w_entry.lost = '0;
            if (r_en) begin
                w_entry.due = now_plus;
            end
        end
    end

    // ---------------- control ----------------
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        div_start  = 1'b0;
        ram_we     = 1'b0;
        beat_load  = 1'b0;
        unique case (r_state)
            pts_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = pts_pkg::S_EVAL;
                end
            end
            pts_pkg::S_EVAL: begin
                if (fire_c) begin
                    div_start = 1'b1;
                    n_state   = pts_pkg::S_DIV;
                end else if (ch_ok && (r_mode == pts_pkg::MODE_RESTART ||
                                       r_mode == pts_pkg::MODE_RST_LOST)) begin
                    n_state = pts_pkg::S_WRITE;
                end else begin
                    n_state = pts_pkg::S_EMIT;
                end
            end
            pts_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = pts_pkg::S_WRITE;
                end
            end
            pts_pkg::S_WRITE: begin
                ram_we  = 1'b1;
                n_state = pts_pkg::S_EMIT;
            end
            pts_pkg::S_EMIT: begin
                if (out_free) begin
                    beat_load = 1'b1;
                    if (beat_last) begin
                        n_state = pts_pkg::S_IDLE;
                    end
                end
            end
            default: n_state = pts_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pts_pkg::S_IDLE;
            r_ent_valid <= '0;
        end else begin
            r_state <= n_state;
            if (ram_we) begin
                r_ent_valid[ch_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mode    <= pts_pkg::t_mode'(i_mode);
            r_ch      <= i_channel;
            r_now     <= i_now_ms;
            r_time_us <= 42'(i_now_ms) * pts_pkg::US_PER_MS;
        end
        if (r_state == pts_pkg::S_EVAL) begin
            r_entry  <= rd_entry;
            r_fire   <= fire_c;
            r_en     <= en_c;
            r_per    <= per_c;
            r_words  <= words_c;
            r_pat    <= pts_pkg::t_pattern'(r_pattern[2 * r_ch +: 2]);
            r_lost_q <= '0;
            r_widx   <= '0;
        end
        if (r_state == pts_pkg::S_WRITE) begin
            r_entry <= w_entry;
            r_base  <= 32'(r_entry.sample * 32'(r_words));
            if (r_fire) begin
                r_lost_q <= div_q;
            end
        end
        if (beat_load && !beat_last) begin
            r_widx <= r_widx + 1'b1;
        end
    end

    // ---------------- beat assembly ----------------
    logic [31:0] s_val;
    logic [31:0] idx32;
    logic [31:0] word_c;

    always_comb begin
        s_val     = r_entry.sample;
        idx32     = 32'(r_widx);
        beat_last = r_fire ? (idx32 + 32'd1 == 32'(r_words)) : 1'b1;
        if (r_widx == pts_pkg::WIDX_W'(0)) begin
            word_c = s_val;
        end else if (r_widx == pts_pkg::WIDX_W'(1)) begin
            word_c = (r_ch == 2'd0) ? pts_pkg::EP_CH0 :
                     (r_ch == 2'd1) ? pts_pkg::EP_CH1 : 32'd0;
        end else if (r_widx == pts_pkg::WIDX_W'(2)) begin
            word_c = {24'd0, s_val[7:0] - 8'd1};
        end else begin
            case (r_pat)
                pts_pkg::PAT_RAMP:   word_c = r_base + idx32;
                pts_pkg::PAT_TOGGLE: word_c = (s_val[0] ^ idx32[0]) ? pts_pkg::TOGGLE_ODD
                                                                    : pts_pkg::TOGGLE_EVEN;
                default: begin
                    if (r_widx == pts_pkg::WIDX_W'(3)) begin
                        word_c = pts_pkg::CNT_MARK | s_val;
                    end else begin
                        word_c = {s_val[23:0], 8'd0} | idx32;
                    end
                end
            endcase
        end
    end

    // ---------------- output register ----------------
    logic r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (beat_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (beat_load) begin
            o_fired          <= r_fire;
            o_event_channel  <= r_ch;
            o_time_us        <= r_time_us;
            o_overflow       <= r_fire && (r_lost_q != '0);
            o_missed_periods <= r_fire ? r_lost_q : 32'd0;
            o_sample_number  <= r_fire ? s_val : 32'd0;
            o_word_index     <= r_fire ? 4'(r_widx) : 4'd0;
            o_data_word      <= r_fire ? word_c : 32'd0;
            o_last           <= beat_last;
            o_emitted_total  <= r_entry.emitted;
            o_lost_total     <= r_entry.lost;
        end
    end

    assign o_out_valid = r_ovalid;

`ifndef SYNTHESIS
    a_idle_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pts_pkg::S_IDLE) |-> !div_busy)
        else $error("divider busy while idle");

    a_fire_bumps_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pts_pkg::S_WRITE && r_fire) |=>
            (r_entry.sample == $past(r_entry.sample) + 32'd1))
        else $error("sample count not advanced on fire");

    a_widx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pts_pkg::S_EMIT && r_fire) |-> (32'(r_widx) < 32'(r_words)))
        else $error("word index past word count");

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_fired) |-> o_last)
        else $error("status beat without last");
`endif

endmodule

### rtl/pts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module pts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/pts_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_div
// Radix-4 restoring divider: lateness over period, two quotient bits per
// cycle, done pulses in the cycle after the final step.
// ----------------------------------------------------------------------------
module pts_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pts_pkg::LATE_W-1:0] i_dividend,
    input  logic [pts_pkg::PER_W-1:0]  i_divisor,
    output logic                       o_busy,
    output logic                       o_done,
    output logic [pts_pkg::LATE_W-1:0] o_quotient
);

    localparam int STEPS  = pts_pkg::LATE_W / 2;
    localparam int CNT_W  = $clog2(STEPS);

    logic                       r_busy;
    logic                       r_done;
    logic [CNT_W-1:0]           r_cnt;
    logic [pts_pkg::LATE_W-1:0] r_quo;
    logic [pts_pkg::PER_W-1:0]  r_rem;
    logic [pts_pkg::PER_W-1:0]  r_div;

    logic [pts_pkg::LATE_W-1:0] n_quo;
    logic [pts_pkg::PER_W-1:0]  n_rem;
    logic [pts_pkg::PER_W:0]    rem_sh;

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        rem_sh = '0;
        for (int k = 0; k < 2; k++) begin
            rem_sh = {n_rem, n_quo[pts_pkg::LATE_W-1]};
            n_quo  = {n_quo[pts_pkg::LATE_W-2:0], 1'b0};
            if (rem_sh >= {1'b0, r_div}) begin
                rem_sh   = rem_sh - {1'b0, r_div};
                n_quo[0] = 1'b1;
            end
            n_rem = rem_sh[pts_pkg::PER_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
